@@ hw/rtl/slpg_pkg.sv @@
// Shared types and constants of the status LED pattern generator.
package slpg_pkg;

    // Indication modes, same encoding on the input and the result channel
    typedef enum logic [2:0] {
        MODE_OFF          = 3'd0,
        MODE_DISCONNECTED = 3'd1,
        MODE_TENTATIVE    = 3'd2,
        MODE_CONNECTED    = 3'd3,
        MODE_BINDING      = 3'd4,
        MODE_WIFI         = 3'd5,
        MODE_ERROR        = 3'd6,
        MODE_BOOT         = 3'd7
    } mode_t;

    // Input item opcodes
    typedef enum logic [1:0] {
        OP_TICK      = 2'd0,
        OP_SET_MODE  = 2'd1,
        OP_LED_WRITE = 2'd2,
        OP_TOGGLE    = 2'd3
    } opcode_t;

    // Double-blink phases
    typedef enum logic [1:0] {
        PHASE_FIRST_ON  = 2'd0,
        PHASE_GAP       = 2'd1,
        PHASE_SECOND_ON = 2'd2,
        PHASE_PAUSE     = 2'd3
    } phase_t;

    // Configuration register map
    localparam int REG_ADDR_WIDTH = 5;
    localparam int REG_IDX_WIDTH  = 3;
    localparam int TIME_WIDTH     = 16;

    localparam logic [REG_IDX_WIDTH-1:0] REG_SLOW_HALF    = 3'd0;
    localparam logic [REG_IDX_WIDTH-1:0] REG_MEDIUM_HALF  = 3'd1;
    localparam logic [REG_IDX_WIDTH-1:0] REG_FAST_HALF    = 3'd2;
    localparam logic [REG_IDX_WIDTH-1:0] REG_RAPID_HALF   = 3'd3;
    localparam logic [REG_IDX_WIDTH-1:0] REG_DOUBLE_ON    = 3'd4;
    localparam logic [REG_IDX_WIDTH-1:0] REG_DOUBLE_GAP   = 3'd5;
    localparam logic [REG_IDX_WIDTH-1:0] REG_DOUBLE_PAUSE = 3'd6;

    // Register reset values, in ticks
    localparam logic [TIME_WIDTH-1:0] SLOW_HALF_RST    = 16'd500;
    localparam logic [TIME_WIDTH-1:0] MEDIUM_HALF_RST  = 16'd250;
    localparam logic [TIME_WIDTH-1:0] FAST_HALF_RST    = 16'd50;
    localparam logic [TIME_WIDTH-1:0] RAPID_HALF_RST   = 16'd75;
    localparam logic [TIME_WIDTH-1:0] DOUBLE_ON_RST    = 16'd100;
    localparam logic [TIME_WIDTH-1:0] DOUBLE_GAP_RST   = 16'd100;
    localparam logic [TIME_WIDTH-1:0] DOUBLE_PAUSE_RST = 16'd600;

endpackage

@@ hw/rtl/status_led_pattern_generator.sv @@
// Status LED pattern generator: next-state logic, registered result and APB registers.
//
// Takes one item per clock while s_ready is high: a 1 ms tick, a mode change, a
// direct LED write or a toggle, and returns one result per item (LED level,
// current mode, double-blink phase) in the cycle after the transfer. The mode,
// tick counter, LED level and phase registers are updated in the cycle of the
// transfer by one saturating increment and one compare against the selected
// half-period or phase length, so the sustained rate is one item per cycle while
// results are taken. The result sits in an output register; s_ready is high
// whenever that register is empty or being taken, so input stalls only for as
// long as a result is held off by m_ready. No clearing pass after reset. The user must
// write timing registers over APB only while the block is idle; the block does not check.
module status_led_pattern_generator
    import slpg_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    // input item channel
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [1:0]                s_opcode,
    input  logic [2:0]                s_mode_value,
    input  logic                      s_led_value,
    // result channel
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic                      m_led_on,
    output logic [2:0]                m_mode_now,
    output logic [1:0]                m_blink_phase,
    // configuration port
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [REG_ADDR_WIDTH-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);

    localparam int CMP_WIDTH = (COUNT_WIDTH > TIME_WIDTH) ? COUNT_WIDTH : TIME_WIDTH;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    // timing registers
    logic [TIME_WIDTH-1:0] slow_half_reg, medium_half_reg, fast_half_reg, rapid_half_reg;
    logic [TIME_WIDTH-1:0] double_on_reg, double_gap_reg, double_pause_reg;

    // indication state
    mode_t                  mode_reg,  mode_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    logic                   led_reg,   led_next;
    phase_t                 phase_reg, phase_next;

    // result register
    logic       out_valid_reg;
    logic       out_led_reg;
    logic [2:0] out_mode_reg;
    logic [1:0] out_phase_reg;

    logic                   in_xfer;
    logic                   cfg_write;
    logic [REG_IDX_WIDTH-1:0] cfg_idx;
    logic [COUNT_WIDTH-1:0] count_inc;
    logic [TIME_WIDTH-1:0]  limit;
    logic                   blink_en;
    logic                   wifi_en;
    logic                   limit_hit;
    phase_t                 phase_adv;
    mode_t                  req_mode;

    assign s_ready   = !out_valid_reg || m_ready;
    assign in_xfer   = s_valid && s_ready;
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = paddr[REG_ADDR_WIDTH-1:2];
    assign req_mode  = mode_t'(s_mode_value);

    // APB register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slow_half_reg    <= SLOW_HALF_RST;
            medium_half_reg  <= MEDIUM_HALF_RST;
            fast_half_reg    <= FAST_HALF_RST;
            rapid_half_reg   <= RAPID_HALF_RST;
            double_on_reg    <= DOUBLE_ON_RST;
            double_gap_reg   <= DOUBLE_GAP_RST;
            double_pause_reg <= DOUBLE_PAUSE_RST;
        end else if (cfg_write) begin
            unique case (cfg_idx)
                REG_SLOW_HALF:    slow_half_reg    <= pwdata[TIME_WIDTH-1:0];
                REG_MEDIUM_HALF:  medium_half_reg  <= pwdata[TIME_WIDTH-1:0];
                REG_FAST_HALF:    fast_half_reg    <= pwdata[TIME_WIDTH-1:0];
                REG_RAPID_HALF:   rapid_half_reg   <= pwdata[TIME_WIDTH-1:0];
                REG_DOUBLE_ON:    double_on_reg    <= pwdata[TIME_WIDTH-1:0];
                REG_DOUBLE_GAP:   double_gap_reg   <= pwdata[TIME_WIDTH-1:0];
                REG_DOUBLE_PAUSE: double_pause_reg <= pwdata[TIME_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // APB read-back
    always_comb begin
        prdata = '0;
        unique case (cfg_idx)
            REG_SLOW_HALF:    prdata = 32'(slow_half_reg);
            REG_MEDIUM_HALF:  prdata = 32'(medium_half_reg);
            REG_FAST_HALF:    prdata = 32'(fast_half_reg);
            REG_RAPID_HALF:   prdata = 32'(rapid_half_reg);
            REG_DOUBLE_ON:    prdata = 32'(double_on_reg);
            REG_DOUBLE_GAP:   prdata = 32'(double_gap_reg);
            REG_DOUBLE_PAUSE: prdata = 32'(double_pause_reg);
            default:          prdata = '0;
        endcase
    end

    // saturating tick counter
    assign count_inc = (count_reg == COUNT_MAX) ? count_reg : count_reg + 1'b1;

    // limit for the current mode (and phase in wifi mode)
    always_comb begin
        limit    = '0;
        blink_en = 1'b0;
        wifi_en  = 1'b0;
        unique case (mode_reg)
            MODE_DISCONNECTED: begin limit = slow_half_reg;   blink_en = 1'b1; end
            MODE_TENTATIVE:    begin limit = medium_half_reg; blink_en = 1'b1; end
            MODE_BINDING:      begin limit = fast_half_reg;   blink_en = 1'b1; end
            MODE_ERROR:        begin limit = rapid_half_reg;  blink_en = 1'b1; end
            MODE_WIFI: begin
                wifi_en = 1'b1;
                case (phase_reg)
                    PHASE_FIRST_ON, PHASE_SECOND_ON: limit = double_on_reg;
                    PHASE_GAP:                       limit = double_gap_reg;
                    default:                         limit = double_pause_reg;
                endcase
            end
            default: ;
        endcase
    end

    assign limit_hit = CMP_WIDTH'(count_inc) >= CMP_WIDTH'(limit);
    assign phase_adv = phase_t'(phase_reg + 2'd1);

    // next state for the item in transfer
    always_comb begin
        mode_next  = mode_reg;
        count_next = count_reg;
        led_next   = led_reg;
        phase_next = phase_reg;
        unique case (opcode_t'(s_opcode))
            OP_TICK: begin
                count_next = count_inc;
                if (limit_hit && blink_en) begin
                    count_next = '0;
                    led_next   = !led_reg;
                end else if (limit_hit && wifi_en) begin
                    count_next = '0;
                    phase_next = phase_adv;
                    // lit in both flash phases
                    led_next   = !phase_adv[0];
                end
            end
            OP_SET_MODE: begin
                if (req_mode != mode_reg) begin
                    mode_next  = req_mode;
                    count_next = '0;
                    phase_next = PHASE_FIRST_ON;
                    led_next   = !(req_mode == MODE_OFF || req_mode == MODE_BOOT);
                end
            end
            OP_LED_WRITE: led_next = s_led_value;
            OP_TOGGLE:    led_next = !led_reg;
            default: ;
        endcase
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_OFF;
            count_reg <= '0;
            led_reg   <= 1'b0;
            phase_reg <= PHASE_FIRST_ON;
        end else if (in_xfer) begin
            mode_reg  <= mode_next;
            count_reg <= count_next;
            led_reg   <= led_next;
            phase_reg <= phase_next;
        end
    end

    // result register: valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (s_ready) begin
            out_valid_reg <= in_xfer;
        end
    end

    // result register: payload
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            out_led_reg   <= led_next;
            out_mode_reg  <= mode_next;
            out_phase_reg <= phase_next;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_led_on      = out_led_reg;
    assign m_mode_now    = out_mode_reg;
    assign m_blink_phase = out_phase_reg;

endmodule

@@ hw/rtl/slpg_checker.sv @@
// Port-level assertions for the status LED pattern generator, bound to the top level.
module slpg_checker
    import slpg_pkg::*;
(
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_valid,
    input logic                      s_ready,
    input logic [1:0]                s_opcode,
    input logic [2:0]                s_mode_value,
    input logic                      s_led_value,
    input logic                      m_valid,
    input logic                      m_ready,
    input logic                      m_led_on,
    input logic [2:0]                m_mode_now,
    input logic [1:0]                m_blink_phase
);

    logic in_xfer;
    assign in_xfer = s_valid && s_ready;

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_led_on) && $stable(m_mode_now)
            && $stable(m_blink_phase))
        else $error("result changed while stalled");

    // every input transfer yields a result in the next cycle
    a_one_result: assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer |=> m_valid)
        else $error("input transfer without result");

    // a mode change shows up as the reported mode
    a_set_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer && s_opcode == OP_SET_MODE |=> m_mode_now == $past(s_mode_value))
        else $error("mode not taken");

    // a direct write sets the LED level
    a_led_write: assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer && s_opcode == OP_LED_WRITE |=> m_led_on == $past(s_led_value))
        else $error("direct LED write lost");

    // a toggle right after another toggle leaves the reported mode and phase alone
    a_toggle_keeps: assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer && s_opcode == OP_TOGGLE ##1 in_xfer && s_opcode == OP_TOGGLE
            |=> m_mode_now == $past(m_mode_now) && m_blink_phase == $past(m_blink_phase))
        else $error("toggle changed mode or phase");

endmodule

bind status_led_pattern_generator slpg_checker u_slpg_checker (.*);

@@ sim/status_led_pattern_generator_tb.sv @@
// Self-checking testbench for the status LED pattern generator: predictor, driver, monitor.
`timescale 1ns / 100ps

module status_led_pattern_generator_tb;
    import slpg_pkg::*;

    localparam int COUNT_W     = 16;
    localparam int HOLD_CYCLES = 64;
    localparam int PHASE_ITEMS = 200;
    localparam int RAND_PHASES = 7;

    typedef struct {
        opcode_t op;
        mode_t   mode;
        logic    led;
    } led_cmd_t;

    typedef struct {
        logic   led_on;
        mode_t  mode_now;
        phase_t blink_phase;
    } led_status_t;

    // Clock and reset
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    // Input channel
    logic       s_valid      = 1'b0;
    logic       s_ready;
    logic [1:0] s_opcode     = OP_TICK;
    logic [2:0] s_mode_value = MODE_OFF;
    logic       s_led_value  = 1'b0;

    // Result channel
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic       m_led_on;
    logic [2:0] m_mode_now;
    logic [1:0] m_blink_phase;

    // Register port
    logic                      psel    = 1'b0;
    logic                      penable = 1'b0;
    logic                      pwrite  = 1'b0;
    logic [REG_ADDR_WIDTH-1:0] paddr   = '0;
    logic [31:0]               pwdata  = '0;
    logic [31:0]               prdata;
    logic                      pready;

    // Pending input transfers and results still owed by the block
    led_cmd_t    cmd_q[$];
    led_status_t status_q[$];
    led_cmd_t    next_cmd;

    // Predictor copy of the block state and timing registers
    logic [TIME_WIDTH-1:0] timing_cfg [REG_DOUBLE_PAUSE+1];
    logic [TIME_WIDTH-1:0] timing_rst [REG_DOUBLE_PAUSE+1];
    mode_t                 cur_mode  = MODE_OFF;
    logic [COUNT_W-1:0]    tick_cnt  = '0;
    logic                  led_lit   = 1'b0;
    phase_t                cur_phase = PHASE_FIRST_ON;

    // Flow control
    int   src_gap      = 0;
    int   sink_gap     = 0;
    int   hold_cnt     = 0;
    logic hold_start   = 1'b0;
    logic steady_flow  = 1'b0;

    int mismatch_count = 0;
    int items_taken    = 0;
    int results_seen   = 0;
    int settings_used  = 0;

    status_led_pattern_generator #(
        .COUNT_WIDTH(COUNT_W)
    ) u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_opcode     (s_opcode),
        .s_mode_value (s_mode_value),
        .s_led_value  (s_led_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_led_on     (m_led_on),
        .m_mode_now   (m_mode_now),
        .m_blink_phase(m_blink_phase),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // Next LED status for one item; updates the predictor state
    function automatic led_status_t advance_status(opcode_t op, mode_t mv, logic lv);
        led_status_t           res;
        logic [TIME_WIDTH-1:0] limit;
        logic                  blinking;
        limit    = '1;
        blinking = 1'b1;
        case (op)
            OP_TICK: begin
                if (tick_cnt != '1) tick_cnt = tick_cnt + 1'b1;
                case (cur_mode)
                    MODE_DISCONNECTED: limit = timing_cfg[REG_SLOW_HALF];
                    MODE_TENTATIVE:    limit = timing_cfg[REG_MEDIUM_HALF];
                    MODE_BINDING:      limit = timing_cfg[REG_FAST_HALF];
                    MODE_ERROR:        limit = timing_cfg[REG_RAPID_HALF];
                    MODE_WIFI: begin
                        case (cur_phase)
                            PHASE_GAP:   limit = timing_cfg[REG_DOUBLE_GAP];
                            PHASE_PAUSE: limit = timing_cfg[REG_DOUBLE_PAUSE];
                            default:     limit = timing_cfg[REG_DOUBLE_ON];
                        endcase
                    end
                    default: blinking = 1'b0;
                endcase
                if (blinking && tick_cnt >= limit) begin
                    tick_cnt = '0;
                    if (cur_mode == MODE_WIFI) begin
                        cur_phase = phase_t'(2'(cur_phase + 2'd1));
                        led_lit   = (cur_phase == PHASE_FIRST_ON || cur_phase == PHASE_SECOND_ON);
                    end else begin
                        led_lit = ~led_lit;
                    end
                end
            end
            OP_SET_MODE: begin
                if (mv != cur_mode) begin
                    cur_mode  = mv;
                    tick_cnt  = '0;
                    cur_phase = PHASE_FIRST_ON;
                    led_lit   = !(mv == MODE_OFF || mv == MODE_BOOT);
                end
            end
            OP_LED_WRITE: led_lit = lv;
            default:      led_lit = ~led_lit;
        endcase
        res.led_on      = led_lit;
        res.mode_now    = cur_mode;
        res.blink_phase = cur_phase;
        return res;
    endfunction

    // Input driver: offers queued items, with random idle bursts
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (src_gap > 0) begin
                src_gap <= src_gap - 1;
                s_valid <= 1'b0;
            end else if (cmd_q.size() == 0) begin
                s_valid <= 1'b0;
            end else if (!steady_flow && $urandom_range(0, 9) == 0) begin
                src_gap <= $urandom_range(0, 8);
                s_valid <= 1'b0;
            end else begin
                next_cmd = cmd_q.pop_front();
                s_valid      <= 1'b1;
                s_opcode     <= next_cmd.op;
                s_mode_value <= next_cmd.mode;
                s_led_value  <= next_cmd.led;
            end
        end
    end

    // Result sink: random stalls plus one long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_start && hold_cnt < HOLD_CYCLES) begin
            hold_cnt <= hold_cnt + 1;
            m_ready  <= 1'b0;
        end else if (sink_gap > 0) begin
            sink_gap <= sink_gap - 1;
            m_ready  <= 1'b0;
        end else if (!steady_flow && $urandom_range(0, 7) == 0) begin
            sink_gap <= $urandom_range(0, 8);
            m_ready  <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Monitor: predict on each input transfer, check each result transfer
    always @(posedge aclk) begin
        led_status_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                status_q.push_back(advance_status(opcode_t'(s_opcode), mode_t'(s_mode_value),
                                                  s_led_value));
                items_taken++;
            end
            if (m_valid && m_ready) begin
                results_seen++;
                if (status_q.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected result led=%0d mode=%0d phase=%0d", $time,
                             m_led_on, m_mode_now, m_blink_phase);
                end else begin
                    want = status_q.pop_front();
                    if (m_led_on !== want.led_on) begin
                        mismatch_count++;
                        $display("%0t: led_on expected %0d actual %0d", $time,
                                 want.led_on, m_led_on);
                    end
                    if (m_mode_now !== want.mode_now) begin
                        mismatch_count++;
                        $display("%0t: mode_now expected %0d actual %0d", $time,
                                 want.mode_now, m_mode_now);
                    end
                    if (m_blink_phase !== want.blink_phase) begin
                        mismatch_count++;
                        $display("%0t: blink_phase expected %0d actual %0d", $time,
                                 want.blink_phase, m_blink_phase);
                    end
                end
            end
        end
    end

    task automatic apb_write(input logic [REG_IDX_WIDTH-1:0] idx,
                             input logic [TIME_WIDTH-1:0] val);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'h0000, val};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        timing_cfg[idx] = val;
    endtask

    task automatic apb_read_check(input logic [REG_IDX_WIDTH-1:0] idx);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata[TIME_WIDTH-1:0] !== timing_cfg[idx]) begin
            mismatch_count++;
            $display("%0t: register %0d read expected %0d actual %0d", $time, idx,
                     timing_cfg[idx], prdata[TIME_WIDTH-1:0]);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic queue_cmd(input opcode_t op, input mode_t mv, input logic lv);
        led_cmd_t c;
        c.op   = op;
        c.mode = mv;
        c.led  = lv;
        cmd_q.push_back(c);
    endtask

    // Sampled away from the active edge so driver and monitor updates have settled
    task automatic wait_drained();
        while (cmd_q.size() != 0 || s_valid || status_q.size() != 0) @(negedge aclk);
    endtask

    function automatic logic [TIME_WIDTH-1:0] pick_timing(int kind, logic [TIME_WIDTH-1:0] rst);
        case (kind)
            0: return TIME_WIDTH'($urandom_range(1, 6));
            1: return TIME_WIDTH'(1);
            2: return '1;
            3: return TIME_WIDTH'($urandom_range(1, 20));
            4: begin
                case ($urandom_range(0, 3))
                    0:       return '0;
                    1:       return TIME_WIDTH'(1);
                    2:       return '1;
                    default: return TIME_WIDTH'($urandom_range(2, 10));
                endcase
            end
            5: return TIME_WIDTH'($urandom_range(1, 4));
            default: return rst;
        endcase
    endfunction

    function automatic led_cmd_t random_cmd(int tick_pct);
        led_cmd_t c;
        int       r;
        r      = $urandom_range(0, 99);
        c.mode = mode_t'(3'($urandom_range(0, 7)));
        c.led  = 1'($urandom_range(0, 1));
        if (r < tick_pct)                       c.op = OP_TICK;
        else if (r < tick_pct + (100 - tick_pct) / 3)     c.op = OP_LED_WRITE;
        else if (r < tick_pct + 2 * (100 - tick_pct) / 3) c.op = OP_TOGGLE;
        else                                    c.op = OP_SET_MODE;
        return c;
    endfunction

    // Stimulus sequence
    initial begin
        int       seg_len;
        int       seg_max;
        int       filled;
        led_cmd_t c;

        timing_rst[REG_SLOW_HALF]    = SLOW_HALF_RST;
        timing_rst[REG_MEDIUM_HALF]  = MEDIUM_HALF_RST;
        timing_rst[REG_FAST_HALF]    = FAST_HALF_RST;
        timing_rst[REG_RAPID_HALF]   = RAPID_HALF_RST;
        timing_rst[REG_DOUBLE_ON]    = DOUBLE_ON_RST;
        timing_rst[REG_DOUBLE_GAP]   = DOUBLE_GAP_RST;
        timing_rst[REG_DOUBLE_PAUSE] = DOUBLE_PAUSE_RST;
        for (int i = REG_SLOW_HALF; i <= REG_DOUBLE_PAUSE; i++) timing_cfg[i] = timing_rst[i];

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Registers come out of reset at their defaults
        for (int i = REG_SLOW_HALF; i <= REG_DOUBLE_PAUSE; i++)
            apb_read_check(REG_IDX_WIDTH'(i));

        // Directed: short periods, slow half-period of zero toggles on every tick
        apb_write(REG_SLOW_HALF, '0);
        apb_write(REG_MEDIUM_HALF, TIME_WIDTH'(1));
        apb_write(REG_FAST_HALF, TIME_WIDTH'(2));
        apb_write(REG_RAPID_HALF, TIME_WIDTH'(3));
        apb_write(REG_DOUBLE_ON, TIME_WIDTH'(1));
        apb_write(REG_DOUBLE_GAP, TIME_WIDTH'(2));
        apb_write(REG_DOUBLE_PAUSE, TIME_WIDTH'(3));
        settings_used++;

        queue_cmd(OP_TICK, MODE_BOOT, 1'b1);           // static off mode, fields ignored
        queue_cmd(OP_SET_MODE, MODE_WIFI, 1'b0);
        repeat (8) queue_cmd(OP_TICK, MODE_OFF, 1'b0); // full double-blink cycle
        queue_cmd(OP_SET_MODE, MODE_WIFI, 1'b1);       // same mode: no change
        queue_cmd(OP_TOGGLE, MODE_BOOT, 1'b1);
        queue_cmd(OP_LED_WRITE, MODE_BOOT, 1'b0);
        queue_cmd(OP_LED_WRITE, MODE_OFF, 1'b1);
        queue_cmd(OP_SET_MODE, MODE_DISCONNECTED, 1'b0);
        repeat (2) queue_cmd(OP_TICK, MODE_ERROR, 1'b1);
        queue_cmd(OP_SET_MODE, MODE_TENTATIVE, 1'b1);
        queue_cmd(OP_TICK, MODE_OFF, 1'b0);
        queue_cmd(OP_SET_MODE, MODE_BINDING, 1'b0);
        repeat (2) queue_cmd(OP_TICK, MODE_OFF, 1'b0);
        queue_cmd(OP_SET_MODE, MODE_ERROR, 1'b0);
        repeat (3) queue_cmd(OP_TICK, MODE_OFF, 1'b0);
        queue_cmd(OP_SET_MODE, MODE_CONNECTED, 1'b0);
        queue_cmd(OP_TICK, MODE_OFF, 1'b0);
        queue_cmd(OP_SET_MODE, MODE_BOOT, 1'b0);
        queue_cmd(OP_SET_MODE, MODE_OFF, 1'b0);
        wait_drained();

        // Random phases, each under its own timing setting
        for (int p = 0; p < RAND_PHASES; p++) begin
            for (int i = REG_SLOW_HALF; i <= REG_DOUBLE_PAUSE; i++)
                apb_write(REG_IDX_WIDTH'(i), pick_timing(p, timing_rst[i]));
            for (int i = REG_SLOW_HALF; i <= REG_DOUBLE_PAUSE; i++)
                apb_read_check(REG_IDX_WIDTH'(i));
            settings_used++;
            if (p == RAND_PHASES - 1) steady_flow <= 1'b1;

            // Mode change followed by a run of mostly ticks, plus some noise
            seg_max = (p == RAND_PHASES - 1) ? 160 : 30;
            filled  = 0;
            while (filled < PHASE_ITEMS) begin
                if ($urandom_range(0, 9) == 0) begin
                    c = random_cmd(25);
                end else begin
                    c    = random_cmd(0);
                    c.op = OP_SET_MODE;
                end
                cmd_q.push_back(c);
                filled++;
                seg_len = $urandom_range(1, seg_max);
                for (int k = 0; k < seg_len && filled < PHASE_ITEMS; k++) begin
                    cmd_q.push_back(random_cmd(85));
                    filled++;
                end
            end
            // Long result hold-off while the sender keeps offering
            if (p == 2) hold_start <= 1'b1;
            wait_drained();
        end

        repeat (8) @(posedge aclk);
        $display("Covered %0d input transfers and %0d results over %0d timing settings,",
                 items_taken, results_seen, settings_used);
        $display("including zero and full-scale periods, result hold-off and gap-free flow.");
        if (mismatch_count == 0) begin
            $display("status_led_pattern_generator_tb: done, clean");
        end else begin
            $display("status_led_pattern_generator_tb: done, errors");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #3_000_000;
        $display("status_led_pattern_generator_tb: done, errors");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/slpg_pkg.sv
hw/rtl/status_led_pattern_generator.sv
hw/rtl/slpg_checker.sv
sim/status_led_pattern_generator_tb.sv
